// ===== rtl/core/sql_pkg.sv =====
// ----------------------------------------------------------------------------
// Stream quality limiter package
// Shared types, codes and fixed widths of the stream quality limiter.
// ----------------------------------------------------------------------------
package sql_pkg;

  localparam int unsigned W_SIZE     = 13;
  localparam int unsigned W_FULL     = 15;
  localparam int unsigned W_PERIOD   = 11;
  localparam int unsigned W_PER_OUT  = 10;
  localparam int unsigned W_SKIP     = 8;
  localparam int unsigned W_CFG      = 13;
  localparam int unsigned W_IN_DATA  = 40;
  localparam int unsigned W_OUT_DATA = 72;

  localparam logic [W_SIZE-1:0] SIZE_MAX    = 13'd8191;
  localparam logic signed [5:0] LEVEL_LIMIT = 6'sd6;
  localparam logic signed [5:0] LEVEL_MAX   = 6'sd31;
  localparam logic signed [5:0] LEVEL_RESET = -6'sd1;
  localparam logic [W_SKIP-1:0] SKIP_STOP   = 8'd3;
  localparam logic [W_SKIP-1:0] SKIP_STRIDE = 8'd3;
  localparam logic [W_SKIP-1:0] CONG_MAX    = 8'd255;

  localparam logic [W_SIZE-1:0]   RST_WIDTH  = 13'd640;
  localparam logic [W_SIZE-1:0]   RST_HEIGHT = 13'd480;
  localparam logic [W_PERIOD-1:0] RST_PERIOD = 11'd100;

  typedef enum logic {
    FUNC_REPORT = 1'b0,
    FUNC_RESIZE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    REG_INIT_WIDTH  = 2'd0,
    REG_INIT_HEIGHT = 2'd1,
    REG_INIT_PERIOD = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_HALVE  = 2'd0,
    OP_DOUBLE = 2'd1,
    OP_ADD    = 2'd2,
    OP_SUB    = 2'd3
  } alu_op_e;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_REPORT = 12'b000000000010,
    S_CALM   = 12'b000000000100,
    S_DBL_W  = 12'b000000001000,
    S_DBL_H  = 12'b000000010000,
    S_PASS   = 12'b000000100000,
    S_HLV_W  = 12'b000001000000,
    S_HLV_H  = 12'b000010000000,
    S_RSZ_W  = 12'b000100000000,
    S_RSZ_H  = 12'b001000000000,
    S_DONE   = 12'b010000000000,
    S_SPARE  = 12'b100000000000
  } state_e;

  typedef struct packed {
    logic                func;
    logic [W_SKIP-1:0]   skipped;
    logic [W_SIZE-1:0]   new_width;
    logic [W_SIZE-1:0]   new_height;
  } item_t;

  typedef struct packed {
    logic [W_SIZE-1:0]   width;
    logic [W_SIZE-1:0]   height;
    logic [W_PERIOD-1:0] period;
    logic [1:0]          factor;
    logic                stopped;
    logic                changed;
  } result_t;

endpackage

// ===== rtl/core/stream_quality_limiter.sv =====
// ----------------------------------------------------------------------------
// Stream quality limiter
// Adapts stream resolution and update period to reported frame skips and resizes.
// ----------------------------------------------------------------------------
// Usage: each transfer on the s_axis side is one item. tuser selects a skip
// report (0) or a resize to a new full frame size (1). Every item yields
// exactly one result transfer on the m_axis side with the current size,
// period, stop and change flags, and the size scaled back up by the factor.
// Configuration writes on cfg_we_i load the starting width, height and
// period straight into the live state; the user must make them only while
// the block idles, which the block itself does not enforce. A report may
// take a calm step-down, which can double the size, or one congestion pass
// per three skipped frames; a pass lengthens the period or halves width and
// height. A resize halves width and height factor - 1 times. The done state
// hands the result to the output register before the next item is taken.
// All passes run through one shared add/halve/double unit, one op a cycle.
// Reset restores 640 x 480, a period of 100 ms, factor 1 and an empty
// output. A stalled receiver holds the result in the output register; one
// more item can complete its work behind it and then waits.
// ----------------------------------------------------------------------------
module stream_quality_limiter #(
  parameter int unsigned MAX_FACTOR  = 3,
  parameter int unsigned MAX_PERIOD  = 500,
  parameter int unsigned PERIOD_STEP = 50
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // skipped_frames[7:0], new_width[20:8], new_height[33:21], zero fill
  input  logic [sql_pkg::W_IN_DATA-1:0]     s_axis_tdata,
  // func
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // cur_width[12:0], cur_height[25:13], update_period[35:26], stopped[36],
  // res_changed[37], full_width[52:38], full_height[67:53], zero fill
  output logic [sql_pkg::W_OUT_DATA-1:0]    m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [sql_pkg::W_CFG-1:0]         cfg_data_i
);
  import sql_pkg::*;

  item_t                 item;
  result_t               res;
  logic                  idle;
  logic                  done;
  logic                  res_ready;
  logic                  load;
  logic [1:0]            shift;
  logic [W_FULL-1:0]     full_w;
  logic [W_FULL-1:0]     full_h;
  logic                  out_valid_q, out_valid_d;
  logic [W_OUT_DATA-1:0] out_data_q, out_data_d;

  assign item.func       = s_axis_tuser;
  assign item.skipped    = s_axis_tdata[7:0];
  assign item.new_width  = s_axis_tdata[20:8];
  assign item.new_height = s_axis_tdata[33:21];

  sql_ctrl #(
    .MAX_FACTOR (MAX_FACTOR),
    .MAX_PERIOD (MAX_PERIOD),
    .PERIOD_STEP(PERIOD_STEP)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s_axis_tvalid && idle),
    .item_i     (item),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .res_ready_i(res_ready),
    .idle_o     (idle),
    .done_o     (done),
    .res_o      (res)
  );

  assign s_axis_tready = idle;
  assign res_ready     = !out_valid_q || m_axis_tready;
  assign load          = done && res_ready;

  // The factor is at least one, so the scale-up shift is factor - 1.
  assign shift  = res.factor - 2'd1;
  assign full_w = W_FULL'({2'b00, res.width} << shift);
  assign full_h = W_FULL'({2'b00, res.height} << shift);

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_data_d  = {4'b0000, full_h, full_w, res.changed, res.stopped,
                     res.period[W_PER_OUT-1:0], res.height, res.width};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/core/sql_alu.sv =====
// ----------------------------------------------------------------------------
// Stream quality limiter arithmetic unit
// Shared unit for halving, saturated doubling and period step add/subtract.
// ----------------------------------------------------------------------------
module sql_alu #(
  parameter int unsigned PERIOD_STEP = 50
) (
  input  sql_pkg::alu_op_e                op_i,
  input  logic [sql_pkg::W_SIZE-1:0]      a_i,
  output logic [sql_pkg::W_SIZE-1:0]      y_o
);
  import sql_pkg::*;

  localparam logic [W_SIZE-1:0] STEP = W_SIZE'(PERIOD_STEP);

  logic [W_SIZE:0] inc;
  logic [W_SIZE:0] dbl;

  assign inc = {1'b0, a_i} + {{W_SIZE{1'b0}}, 1'b1};
  assign dbl = {a_i, 1'b0};

  always_comb begin
    case (op_i)
      OP_HALVE:  y_o = inc[W_SIZE:1];
      // A doubled size saturates at the largest 13-bit value.
      OP_DOUBLE: y_o = dbl[W_SIZE] ? SIZE_MAX : dbl[W_SIZE-1:0];
      OP_ADD:    y_o = a_i + STEP;
      OP_SUB:    y_o = a_i - STEP;
      default:   y_o = a_i;
    endcase
  end

endmodule

// ===== rtl/core/sql_ctrl.sv =====
// ----------------------------------------------------------------------------
// Stream quality limiter sequencer
// Holds the limiter state and steps one item through the shared unit.
// ----------------------------------------------------------------------------
module sql_ctrl #(
  parameter int unsigned MAX_FACTOR  = 3,
  parameter int unsigned MAX_PERIOD  = 500,
  parameter int unsigned PERIOD_STEP = 50
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  sql_pkg::item_t              item_i,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [sql_pkg::W_CFG-1:0]   cfg_data_i,
  input  logic                        res_ready_i,
  output logic                        idle_o,
  output logic                        done_o,
  output sql_pkg::result_t            res_o
);
  import sql_pkg::*;

  localparam logic [1:0]          FACTOR_TOP = 2'(MAX_FACTOR);
  localparam logic [W_PERIOD-1:0] PERIOD_TOP = W_PERIOD'(MAX_PERIOD);
  localparam logic [W_PERIOD-1:0] STEP       = W_PERIOD'(PERIOD_STEP);

  state_e              state_q, state_d;
  logic [W_SIZE-1:0]   width_q, width_d;
  logic [W_SIZE-1:0]   height_q, height_d;
  logic [W_PERIOD-1:0] period_q, period_d;
  logic [1:0]          factor_q, factor_d;
  logic signed [5:0]   level_q, level_d;
  logic [W_SKIP-1:0]   cong_q, cong_d;
  logic                stop_q, stop_d;
  logic                changed_q, changed_d;
  logic [W_SKIP-1:0]   skip_q, skip_d;
  logic [W_SKIP-1:0]   left_q, left_d;
  logic [1:0]          cnt_q, cnt_d;

  alu_op_e             alu_op;
  logic [W_SIZE-1:0]   alu_a;
  logic [W_SIZE-1:0]   alu_y;
  logic [W_SKIP-1:0]   cong_new;
  logic signed [5:0]   level_inc;

  sql_alu #(
    .PERIOD_STEP(PERIOD_STEP)
  ) u_alu (
    .op_i(alu_op),
    .a_i (alu_a),
    .y_o (alu_y)
  );

  assign level_inc = (level_q != LEVEL_MAX) ? level_q + 6'sd1 : level_q;

  always_comb begin
    if (skip_q != '0) begin
      cong_new = (cong_q != CONG_MAX) ? cong_q + 8'd1 : cong_q;
    end else begin
      cong_new = (cong_q != '0) ? cong_q - 8'd1 : cong_q;
    end
  end

  always_comb begin
    case (state_q)
      S_HLV_W, S_RSZ_W: begin
        alu_op = OP_HALVE;
        alu_a  = width_q;
      end
      S_HLV_H, S_RSZ_H: begin
        alu_op = OP_HALVE;
        alu_a  = height_q;
      end
      S_DBL_W: begin
        alu_op = OP_DOUBLE;
        alu_a  = width_q;
      end
      S_DBL_H: begin
        alu_op = OP_DOUBLE;
        alu_a  = height_q;
      end
      S_PASS: begin
        alu_op = OP_ADD;
        alu_a  = W_SIZE'(period_q);
      end
      S_CALM: begin
        alu_op = OP_SUB;
        alu_a  = W_SIZE'(period_q);
      end
      default: begin
        alu_op = OP_HALVE;
        alu_a  = width_q;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    width_d   = width_q;
    height_d  = height_q;
    period_d  = period_q;
    factor_d  = factor_q;
    level_d   = level_q;
    cong_d    = cong_q;
    stop_d    = stop_q;
    changed_d = changed_q;
    skip_d    = skip_q;
    left_d    = left_q;
    cnt_d     = cnt_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (item_i.func == FUNC_RESIZE) begin
            width_d  = item_i.new_width;
            height_d = item_i.new_height;
            cnt_d    = factor_q - 2'd1;
            state_d  = (factor_q > 2'd1) ? S_RSZ_W : S_DONE;
          end else begin
            skip_d  = item_i.skipped;
            state_d = S_REPORT;
          end
        end
      end
      S_REPORT: begin
        stop_d    = 1'b0;
        changed_d = 1'b0;
        cong_d    = cong_new;
        if (cong_new == '0) begin
          if (!level_q[5]) begin
            level_d = level_q - 6'sd1;
            state_d = S_CALM;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          stop_d  = (skip_q > SKIP_STOP);
          left_d  = skip_q;
          state_d = (skip_q != '0) ? S_PASS : S_DONE;
        end
      end
      S_CALM: begin
        // The level was already stepped down; -1 counts as odd.
        if ((level_q < LEVEL_LIMIT) && !level_q[0] && (factor_q > 2'd1)) begin
          state_d = S_DBL_W;
        end else begin
          if (period_q > STEP) begin
            period_d = alu_y[W_PERIOD-1:0];
          end
          state_d = S_DONE;
        end
      end
      S_DBL_W: begin
        width_d = alu_y;
        state_d = S_DBL_H;
      end
      S_DBL_H: begin
        height_d  = alu_y;
        factor_d  = factor_q - 2'd1;
        changed_d = 1'b1;
        state_d   = S_DONE;
      end
      S_PASS: begin
        if ((factor_q < FACTOR_TOP) && !level_q[0]) begin
          level_d = level_inc;
          state_d = S_HLV_W;
        end else if (period_q < PERIOD_TOP) begin
          level_d  = level_inc;
          period_d = alu_y[W_PERIOD-1:0];
          if (left_q <= SKIP_STRIDE) begin
            state_d = S_DONE;
          end else begin
            left_d = left_q - SKIP_STRIDE;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_HLV_W: begin
        width_d = alu_y;
        state_d = S_HLV_H;
      end
      S_HLV_H: begin
        height_d  = alu_y;
        factor_d  = factor_q + 2'd1;
        changed_d = 1'b1;
        if (left_q <= SKIP_STRIDE) begin
          state_d = S_DONE;
        end else begin
          left_d  = left_q - SKIP_STRIDE;
          state_d = S_PASS;
        end
      end
      S_RSZ_W: begin
        width_d = alu_y;
        state_d = S_RSZ_H;
      end
      S_RSZ_H: begin
        height_d = alu_y;
        cnt_d    = cnt_q - 2'd1;
        state_d  = (cnt_q == 2'd1) ? S_DONE : S_RSZ_W;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Writes load the live state at once. The user must send them only while idle; the block does not enforce it.
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INIT_WIDTH:  width_d  = cfg_data_i;
        REG_INIT_HEIGHT: height_d = cfg_data_i;
        REG_INIT_PERIOD: period_d = {1'b0, cfg_data_i[W_PER_OUT-1:0]};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      width_q   <= RST_WIDTH;
      height_q  <= RST_HEIGHT;
      period_q  <= RST_PERIOD;
      factor_q  <= 2'd1;
      level_q   <= LEVEL_RESET;
      cong_q    <= 8'd1;
      stop_q    <= 1'b0;
      changed_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      width_q   <= width_d;
      height_q  <= height_d;
      period_q  <= period_d;
      factor_q  <= factor_d;
      level_q   <= level_d;
      cong_q    <= cong_d;
      stop_q    <= stop_d;
      changed_q <= changed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    skip_q <= skip_d;
    left_q <= left_d;
    cnt_q  <= cnt_d;
  end

  assign idle_o = (state_q == S_IDLE);
  assign done_o = (state_q == S_DONE);

  assign res_o.width   = width_q;
  assign res_o.height  = height_q;
  assign res_o.period  = period_q;
  assign res_o.factor  = factor_q;
  assign res_o.stopped = stop_q;
  assign res_o.changed = changed_q;

endmodule

// ===== rtl/core/sql_chk.sv =====
// ----------------------------------------------------------------------------
// Stream quality limiter checker
// Port-level checks on the limiter's handshakes and sequencing.
// ----------------------------------------------------------------------------
module sql_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [sql_pkg::W_OUT_DATA-1:0]    m_axis_tdata
);
  import sql_pkg::*;

  // A stalled result stays offered.
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its data.
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // Each accepted item keeps the sequencer busy, so the input is not ready in the cycle after a transfer.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after a transfer");

  // A new result only appears as the sequencer hands over a finished item.
  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a finished item");

endmodule

bind stream_quality_limiter sql_chk u_sql_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
